### rtl/core/rot_pkg.sv
package rot_pkg;

    // table geometry
    localparam int SLOTS     = 8;
    localparam int KEY_BITS  = 16;
    localparam int TASK_BITS = 4;

    // fixed port field widths
    localparam int CMD_W    = 2;
    localparam int KEY_IN_W = 16;
    localparam int PRIO_W   = 8;
    localparam int TASK_IN_W = 4;
    localparam int STATUS_W = 3;
    localparam int SLOT_OUT_W = 3;

    // derived widths
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int NF_W   = $clog2(SLOTS + 1);
    localparam int KEY_W  = (KEY_BITS < KEY_IN_W) ? KEY_BITS : KEY_IN_W;
    localparam int TASK_W = (TASK_BITS < TASK_IN_W) ? TASK_BITS : TASK_IN_W;

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);
    localparam logic [NF_W-1:0]   NF_FULL   = NF_W'(SLOTS);

    // command queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);
    localparam logic [QPTR_W-1:0] QLAST  = QPTR_W'(QDEPTH - 1);
    localparam logic [QCNT_W-1:0] QFULL  = QCNT_W'(QDEPTH);

    // command codes on the request port
    localparam logic [CMD_W-1:0] CMD_INIT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_GET  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REL  = 2'd2;

    typedef enum logic [1:0] {
        OP_INIT,
        OP_GET,
        OP_REL,
        OP_NOP
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK,
        ST_FULL,
        ST_NOT_FOUND,
        ST_BUSY,
        ST_NOT_OWNER
    } t_status;

    typedef enum logic {
        BK_IDLE,
        BK_RUN
    } t_back_state;

    typedef struct packed {
        t_op                op;
        logic [KEY_W-1:0]   key;
        logic [PRIO_W-1:0]  prio;
        logic [TASK_W-1:0]  task_id;
    } t_job;

    typedef struct packed {
        t_status                 status;
        logic [SLOT_OUT_W-1:0]   slot;
        logic                    found;
    } t_rsp;

endpackage

### rtl/core/rot_if.sv
interface rot_req_if;
    import rot_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CMD_W-1:0]     cmd;
    logic [KEY_IN_W-1:0]  key;
    logic [PRIO_W-1:0]    prio;
    logic [TASK_IN_W-1:0] task_id;

    modport source (output valid, cmd, key, prio, task_id, input ready);
    modport sink   (input valid, cmd, key, prio, task_id, output ready);
endinterface

interface rot_rsp_if;
    import rot_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [STATUS_W-1:0]   status;
    logic [SLOT_OUT_W-1:0] slot;
    logic                  slot_found;

    modport source (output valid, status, slot, slot_found, input ready);
    modport sink   (input valid, status, slot, slot_found, output ready);
endinterface

### rtl/core/rot_front.sv
module rot_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    rot_req_if.sink       i_req,
    output logic          o_job_valid,
    output rot_pkg::t_job o_job,
    input  logic          i_job_ready
);
    import rot_pkg::*;

    t_job               r_q [QDEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0]  r_count, n_count;
    t_job               in_job;
    logic               push, pop;

    // classify the incoming command
    always_comb begin
        unique case (i_req.cmd)
            CMD_INIT: in_job.op = OP_INIT;
            CMD_GET:  in_job.op = OP_GET;
            CMD_REL:  in_job.op = OP_REL;
            default:  in_job.op = OP_NOP;
        endcase
        in_job.key     = i_req.key[KEY_W-1:0];
        in_job.prio    = i_req.prio;
        in_job.task_id = i_req.task_id[TASK_W-1:0];
    end

    assign i_req.ready = (r_count != QFULL);
    assign push        = i_req.valid && i_req.ready;
    assign o_job_valid = (r_count != '0);
    assign o_job       = r_q[r_rd_ptr];
    assign pop         = o_job_valid && i_job_ready;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == QLAST) ? '0 : r_wr_ptr + QPTR_W'(1);
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == QLAST) ? '0 : r_rd_ptr + QPTR_W'(1);
        end
        if (push && !pop) begin
            n_count = r_count + QCNT_W'(1);
        end else if (pop && !push) begin
            n_count = r_count - QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= in_job;
        end
    end

endmodule

### rtl/core/rot_back.sv
module rot_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_job_valid,
    input  rot_pkg::t_job i_job,
    output logic          o_job_ready,
    rot_rsp_if.source     o_rsp
);
    import rot_pkg::*;

    t_back_state        r_state, n_state;
    t_job               r_job, n_job;
    logic [SLOT_W-1:0]  r_idx, n_idx;
    logic               r_rsp_valid, n_rsp_valid;
    t_rsp               r_rsp, n_rsp;
    logic [SLOTS-1:0]   r_valid, n_valid;
    logic [SLOTS-1:0]   r_owned, n_owned;
    logic [NF_W-1:0]    r_next_free, n_next_free;

    // slot payload, written only when a slot is taken or claimed
    logic [KEY_W-1:0]   r_key   [SLOTS];
    logic [PRIO_W-1:0]  r_prio  [SLOTS];
    logic [TASK_W-1:0]  r_owner [SLOTS];

    logic               wr_init, wr_owner;
    logic               can_finish, cur_hit;
    logic [SLOT_W-1:0]  nf_idx;

    assign nf_idx     = r_next_free[SLOT_W-1:0];
    assign can_finish = !r_rsp_valid || o_rsp.ready;
    assign cur_hit    = r_valid[r_idx] && (r_key[r_idx] == r_job.key);

    always_comb begin
        n_state     = r_state;
        n_job       = r_job;
        n_idx       = r_idx;
        n_rsp_valid = r_rsp_valid && !o_rsp.ready;
        n_rsp       = r_rsp;
        n_valid     = r_valid;
        n_owned     = r_owned;
        n_next_free = r_next_free;
        o_job_ready = 1'b0;
        wr_init     = 1'b0;
        wr_owner    = 1'b0;

        unique case (r_state)
            BK_IDLE: begin
                o_job_ready = 1'b1;
                if (i_job_valid) begin
                    n_job   = i_job;
                    n_idx   = '0;
                    n_state = BK_RUN;
                end
            end
            BK_RUN: begin
                unique case (r_job.op)
                    OP_NOP: begin
                        if (can_finish) begin
                            n_rsp_valid = 1'b1;
                            n_rsp       = '{status: ST_OK, slot: '0, found: 1'b0};
                            n_state     = BK_IDLE;
                        end
                    end
                    OP_INIT: begin
                        if (can_finish) begin
                            n_rsp_valid = 1'b1;
                            n_state     = BK_IDLE;
                            if (r_next_free == NF_FULL) begin
                                n_rsp = '{status: ST_FULL, slot: '0, found: 1'b0};
                            end else begin
                                n_valid[nf_idx] = 1'b1;
                                n_owned[nf_idx] = 1'b0;
                                wr_init         = 1'b1;
                                n_next_free     = r_next_free + NF_W'(1);
                                n_rsp = '{status: ST_OK, slot: SLOT_OUT_W'(nf_idx),
                                          found: 1'b1};
                            end
                        end
                    end
                    OP_GET, OP_REL: begin
                        if (cur_hit) begin
                            if (can_finish) begin
                                n_rsp_valid = 1'b1;
                                n_state     = BK_IDLE;
                                n_rsp.slot  = SLOT_OUT_W'(r_idx);
                                n_rsp.found = 1'b1;
                                if (r_job.op == OP_GET) begin
                                    if (r_owned[r_idx]) begin
                                        n_rsp.status = ST_BUSY;
                                    end else begin
                                        n_rsp.status   = ST_OK;
                                        n_owned[r_idx] = 1'b1;
                                        wr_owner       = 1'b1;
                                    end
                                end else begin
                                    if (!r_owned[r_idx] ||
                                        (r_owner[r_idx] != r_job.task_id)) begin
                                        n_rsp.status = ST_NOT_OWNER;
                                    end else begin
                                        n_rsp.status   = ST_OK;
                                        n_owned[r_idx] = 1'b0;
                                    end
                                end
                            end
                        end else if (!r_valid[r_idx] || (r_idx == LAST_SLOT)) begin
                            // valid slots are packed from 0, so an empty slot ends the scan
                            if (can_finish) begin
                                n_rsp_valid = 1'b1;
                                n_state     = BK_IDLE;
                                n_rsp = '{status: ST_NOT_FOUND, slot: '0, found: 1'b0};
                            end
                        end else begin
                            n_idx = r_idx + SLOT_W'(1);
                        end
                    end
                    default: begin
                        n_state = BK_IDLE;
                    end
                endcase
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_rsp_valid <= 1'b0;
            r_valid     <= '0;
            r_owned     <= '0;
            r_next_free <= '0;
        end else begin
            r_state     <= n_state;
            r_rsp_valid <= n_rsp_valid;
            r_valid     <= n_valid;
            r_owned     <= n_owned;
            r_next_free <= n_next_free;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job <= n_job;
        r_idx <= n_idx;
        r_rsp <= n_rsp;
        if (wr_init) begin
            r_key[nf_idx]  <= r_job.key;
            r_prio[nf_idx] <= r_job.prio;
        end
        if (wr_owner) begin
            r_owner[r_idx] <= r_job.task_id;
        end
    end

    assign o_rsp.valid      = r_rsp_valid;
    assign o_rsp.status     = r_rsp.status;
    assign o_rsp.slot       = r_rsp.slot;
    assign o_rsp.slot_found = r_rsp.found;

endmodule

### rtl/core/resource_ownership_table.sv
// Flow: a request is parked in the front-end queue, taken into the back end's job
//   register and answered from the response register. Init and unused commands need
//   no scan; get/release scan one slot per cycle from index 0 up to the matching or
//   first empty slot (at most SLOTS-1). The back end takes a new op only once done.
// Reset: synchronous, active low; empties the queue, clears all valid/owned marks
//   and the free pointer. Key, priority and owner storage is not cleared.
module resource_ownership_table (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rot_req_if.sink   i_req,
    rot_rsp_if.source o_rsp
);
    import rot_pkg::*;

    // Front end: takes request transactions, decodes the command into an
    // internal op and parks it in a short queue. Until that queue is full it keeps
    // accepting while the back end is busy scanning or holding a response.
    logic  job_valid;
    logic  job_ready;
    t_job  job;

    rot_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .o_job_valid (job_valid),
        .o_job       (job),
        .i_job_ready (job_ready)
    );

    // Back end: owns the slot table. Init allocates at the free pointer in
    // one step; get/release walk slots from index 0 comparing keys, one per
    // cycle, and act on the first hit. The response sits in an output
    // register, so a stalled consumer only blocks the next completion.
    rot_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_valid),
        .i_job       (job),
        .o_job_ready (job_ready),
        .o_rsp       (o_rsp)
    );

    // A response without a slot is only ok (unused command), full or not found.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && !o_rsp.slot_found |->
            (o_rsp.status == ST_OK) || (o_rsp.status == ST_FULL) ||
            (o_rsp.status == ST_NOT_FOUND))
        else $error("slotless response with slot-bound status");

    // Busy and not-owner always refer to a matched slot.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && ((o_rsp.status == ST_BUSY) || (o_rsp.status == ST_NOT_OWNER))
            |-> o_rsp.slot_found)
        else $error("busy/not-owner without slot");

    // Failed lookups and full table report slot zero.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && ((o_rsp.status == ST_FULL) || (o_rsp.status == ST_NOT_FOUND))
            |-> (o_rsp.slot == '0))
        else $error("nonzero slot on failed transaction");

    // A queued op not taken by the back end stays queued.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        job_valid && !job_ready |=> job_valid)
        else $error("queued op lost");

endmodule

### sim/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rot_pkg::*;

    // cmd 3 has no operation behind it; the table must leave its state alone
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    localparam int RAND_ITEMS   = 580;   // random part, unused commands and extra gets not counted
    localparam int SETTLE_TICKS = 3 * (SLOTS + 3);
    localparam int TIMEOUT_NS   = 5_000_000;

    // one request transaction as it sits in the send queue
    typedef struct packed {
        logic [CMD_W-1:0]     cmd;
        logic [KEY_IN_W-1:0]  key;
        logic [PRIO_W-1:0]    prio;
        logic [TASK_IN_W-1:0] task_id;
        logic                 drain;     // hold back until every response is in
    } t_syscall;

    logic i_clk;
    logic i_rst_n;

    rot_req_if req_if ();
    rot_rsp_if rsp_if ();

    resource_ownership_table u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Shadow of the slot table, updated once per accepted request.
    // ------------------------------------------------------------------
    bit                  shadow_valid [SLOTS];
    logic [KEY_W-1:0]    shadow_key   [SLOTS];
    logic [PRIO_W-1:0]   shadow_prio  [SLOTS];
    bit                  shadow_owned [SLOTS];
    logic [TASK_W-1:0]   shadow_owner [SLOTS];
    int unsigned         shadow_next_free;

    t_syscall syscall_q [$];        // requests not yet presented
    t_rsp     owner_status_q [$];   // predicted responses, oldest first
    t_syscall cur_call;             // request currently on the bus

    int unsigned sent_cnt;
    int unsigned rcvd_cnt;
    int unsigned total_calls;
    int unsigned err_cnt;

    logic [KEY_IN_W-1:0] key_pool [SLOTS];   // keys placed by the init sequence

    // Apply one request to the shadow table and return the response it earns.
    // Lookups hit the lowest-indexed valid slot; freed slots are never reused.
    function automatic t_rsp owner_table_step(t_syscall call);
        t_rsp             r;
        logic [KEY_W-1:0] k;
        logic [TASK_W-1:0] t;
        int               hit;
        k   = call.key[KEY_W-1:0];
        t   = call.task_id[TASK_W-1:0];
        hit = -1;
        r.status = ST_OK;
        r.slot   = '0;
        r.found  = 1'b0;
        if (call.cmd == CMD_INIT) begin
            if (shadow_next_free >= SLOTS) begin
                r.status = ST_FULL;
            end else begin
                shadow_valid[shadow_next_free] = 1'b1;
                shadow_key[shadow_next_free]   = k;
                shadow_prio[shadow_next_free]  = call.prio;
                shadow_owned[shadow_next_free] = 1'b0;
                r.slot  = SLOT_OUT_W'(shadow_next_free);
                r.found = 1'b1;
                shadow_next_free++;
            end
            return r;
        end
        if (call.cmd == CMD_UNUSED)
            return r;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (shadow_valid[i] && shadow_key[i] == k)
                hit = i;
        end
        if (hit < 0) begin
            r.status = ST_NOT_FOUND;
            return r;
        end
        r.slot  = SLOT_OUT_W'(hit);
        r.found = 1'b1;
        if (call.cmd == CMD_GET) begin
            // no waiting: an owned slot is busy even for its own owner
            if (shadow_owned[hit]) begin
                r.status = ST_BUSY;
            end else begin
                shadow_owned[hit] = 1'b1;
                shadow_owner[hit] = t;
            end
        end else begin
            if (!shadow_owned[hit] || shadow_owner[hit] != t)
                r.status = ST_NOT_OWNER;
            else
                shadow_owned[hit] = 1'b0;
        end
        return r;
    endfunction

    // Three load phases over the run: light sender gaps with heavy
    // backpressure, then the reverse, then both sides at full rate.
    function automatic int unsigned load_phase(int unsigned done);
        if (done < total_calls / 3)
            return 0;
        if (done < 2 * total_calls / 3)
            return 1;
        return 2;
    endfunction

    function automatic int unsigned send_gap_pct();
        case (load_phase(sent_cnt))
            0: return 22;
            1: return 51;
            default: return 0;
        endcase
    endfunction

    function automatic int unsigned recv_stall_pct();
        case (load_phase(rcvd_cnt))
            0: return 51;
            1: return 22;
            default: return 0;
        endcase
    endfunction

    // mostly a handful of tasks so ownership actually collides and matches
    function automatic logic [TASK_IN_W-1:0] pick_task();
        if ($urandom_range(0, 4) == 0)
            return TASK_IN_W'($urandom);
        return TASK_IN_W'($urandom_range(0, 3));
    endfunction

    task automatic add_call(logic [CMD_W-1:0] cmd, logic [KEY_IN_W-1:0] key,
                            logic [PRIO_W-1:0] prio, logic [TASK_IN_W-1:0] tid);
        t_syscall c;
        c.cmd     = cmd;
        c.key     = key;
        c.prio    = prio;
        c.task_id = tid;
        c.drain   = 1'b0;
        syscall_q.push_back(c);
    endtask

    // ------------------------------------------------------------------
    // Request driver: a new transaction goes out only once the previous one
    // was taken; valid holds until ready. Prediction happens on acceptance.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else begin
            if (req_if.valid && req_if.ready) begin
                owner_status_q.push_back(owner_table_step(cur_call));
                sent_cnt++;
            end
            if (!req_if.valid || req_if.ready) begin
                if (syscall_q.size() > 0
                        && !(syscall_q[0].drain && owner_status_q.size() > 0)
                        && $urandom_range(0, 99) >= send_gap_pct()) begin
                    cur_call = syscall_q.pop_front();
                    req_if.valid   <= 1'b1;
                    req_if.cmd     <= cur_call.cmd;
                    req_if.key     <= cur_call.key;
                    req_if.prio    <= cur_call.prio;
                    req_if.task_id <= cur_call.task_id;
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Response monitor: random backpressure, field-by-field check against
    // the oldest prediction.
    // ------------------------------------------------------------------
    t_rsp want;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else begin
            if (rsp_if.valid && rsp_if.ready) begin
                if (owner_status_q.size() == 0) begin
                    $error("response with none outstanding: status=%0d slot=%0d found=%0d",
                           rsp_if.status, rsp_if.slot, rsp_if.slot_found);
                    err_cnt++;
                end else begin
                    want = owner_status_q.pop_front();
                    if (rsp_if.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, rsp_if.status);
                        err_cnt++;
                    end
                    if (rsp_if.slot !== want.slot) begin
                        $error("slot: expected %0d, got %0d", want.slot, rsp_if.slot);
                        err_cnt++;
                    end
                    if (rsp_if.slot_found !== want.found) begin
                        $error("slot_found: expected %0d, got %0d",
                               want.found, rsp_if.slot_found);
                        err_cnt++;
                    end
                end
                rcvd_cnt++;
            end
            rsp_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct());
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial begin
        int unsigned          n_rand;
        int unsigned          first_rand;
        int                   r;
        logic [KEY_IN_W-1:0]  k;
        logic [TASK_IN_W-1:0] t;

        i_rst_n        = 1'b0;
        req_if.valid   = 1'b0;
        req_if.cmd     = '0;
        req_if.key     = '0;
        req_if.prio    = '0;
        req_if.task_id = '0;
        rsp_if.ready   = 1'b0;
        sent_cnt       = 0;
        rcvd_cnt       = 0;
        err_cnt        = 0;
        shadow_next_free = 0;
        for (int i = 0; i < SLOTS; i++) begin
            shadow_valid[i] = 1'b0;
            shadow_owned[i] = 1'b0;
        end

        key_pool[0] = 16'h0000;
        key_pool[1] = 16'hFFFF;
        key_pool[2] = 16'h0000;            // duplicate: lookups must stop at slot 0
        key_pool[3] = KEY_IN_W'($urandom);
        key_pool[4] = KEY_IN_W'($urandom);
        key_pool[5] = 16'h8001;
        key_pool[6] = 16'h7FFE;
        key_pool[7] = 16'h1234;            // last slot: longest scan

        // lookups on an empty table
        add_call(CMD_GET, 16'h1234, 8'h00, 4'd3);
        add_call(CMD_REL, 16'h1234, 8'hFF, 4'd3);
        // first three slots, extremes of key and priority, duplicate key
        add_call(CMD_INIT, key_pool[0], 8'h00, 4'd0);
        add_call(CMD_INIT, key_pool[1], 8'hFF, 4'd15);
        add_call(CMD_INIT, key_pool[2], 8'h55, 4'd0);
        // release of an unowned slot
        add_call(CMD_REL, 16'h0000, 8'h00, 4'd0);
        // claim, then busy for the owner itself and for another task
        add_call(CMD_GET, 16'h0000, 8'h00, 4'd15);
        add_call(CMD_GET, 16'h0000, 8'h00, 4'd15);
        add_call(CMD_GET, 16'h0000, 8'h00, 4'd0);
        // release by a foreign task, then by the owner
        add_call(CMD_REL, 16'h0000, 8'h00, 4'd0);
        add_call(CMD_REL, 16'h0000, 8'h00, 4'd15);
        add_call(CMD_GET, 16'hFFFF, 8'hAA, 4'd5);
        add_call(CMD_UNUSED, 16'hFFFF, 8'hFF, 4'd15);
        add_call(CMD_REL, 16'hFFFF, 8'h00, 4'd10);
        add_call(CMD_REL, 16'hFFFF, 8'h00, 4'd5);
        // fill the rest of the table, then overflow it
        for (int i = 3; i < SLOTS; i++)
            add_call(CMD_INIT, key_pool[i], PRIO_W'($urandom), TASK_IN_W'($urandom));
        add_call(CMD_INIT, 16'hBEEF, 8'h01, 4'd1);
        add_call(CMD_GET, 16'h1234, 8'h00, 4'd9);

        // Random part: table is full now, so the traffic is mostly claim/free
        // pairs on live keys, mixed with loose commands and unknown keys.
        first_rand = syscall_q.size();
        n_rand = 0;
        while (n_rand < RAND_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 40) begin
                k = key_pool[$urandom_range(0, SLOTS - 1)];
                t = pick_task();
                add_call(CMD_GET, k, PRIO_W'($urandom), t);
                if ($urandom_range(0, 3) == 0)
                    add_call(CMD_GET, k, PRIO_W'($urandom), pick_task());
                add_call(CMD_REL, k, PRIO_W'($urandom),
                         ($urandom_range(0, 4) == 0) ? pick_task() : t);
                n_rand += 2;
            end else begin
                if ($urandom_range(0, 99) < 85)
                    k = key_pool[$urandom_range(0, SLOTS - 1)];
                else
                    k = KEY_IN_W'($urandom);
                r = $urandom_range(0, 99);
                if (r < 44) begin
                    add_call(CMD_GET, k, PRIO_W'($urandom), pick_task());
                    n_rand++;
                end else if (r < 88) begin
                    add_call(CMD_REL, k, PRIO_W'($urandom), pick_task());
                    n_rand++;
                end else if (r < 96) begin
                    add_call(CMD_INIT, k, PRIO_W'($urandom), pick_task());
                    n_rand++;
                end else begin
                    add_call(CMD_UNUSED, k, PRIO_W'($urandom), pick_task());
                end
            end
        end
        total_calls = syscall_q.size();

        // let the pipeline run dry at the start of random traffic and at
        // each load phase change
        syscall_q[first_rand].drain      = 1'b1;
        syscall_q[total_calls / 3].drain = 1'b1;
        syscall_q[2 * total_calls / 3].drain = 1'b1;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (syscall_q.size() > 0 || req_if.valid || owner_status_q.size() > 0)
            @(posedge i_clk);
        repeat (SETTLE_TICKS) @(posedge i_clk);

        if (err_cnt == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial begin
        #TIMEOUT_NS;
        $display("Some tests failed");
        $finish;
    end

endmodule
